### src/bwg_pkg.sv
// Package for the bootstrap weight generator: widths, constants and state encoding.
`timescale 1ns / 1ps
package bwg_pkg;

  localparam int MAX_SITES      = 512;
  localparam int MAX_REPLICATES = 128;

  localparam int SITE_W   = $clog2(MAX_SITES);
  localparam int REP_W    = $clog2(MAX_REPLICATES);
  localparam int ADDR_W   = SITE_W + REP_W;
  localparam int WEIGHT_W = 10;
  localparam int WIN_W    = 10;
  localparam int RCNT_W   = 8;
  localparam int SEED_W   = 32;
  localparam int DRAW_W   = 15;
  localparam int PROD_W   = DRAW_W + SITE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [SEED_W-1:0] LCG_MUL   = 32'd214013;
  localparam logic [SEED_W-1:0] LCG_ADD   = 32'd2531011;
  localparam logic [SEED_W-1:0] SEED_SUBST = 32'd3;
  localparam logic [DRAW_W:0]   DRAW_MAX  = 16'd32767;
  localparam logic [WIN_W-1:0]  MIN_WINDOW = 10'd5;

  localparam logic [WIN_W-1:0]  WIN_RESET  = 10'd200;
  localparam logic [RCNT_W-1:0] RCNT_RESET = 8'd100;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SITES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLICATE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED     = 2'd2;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_READ     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SKIP1,
    ST_SKIP2,
    ST_DRAW,
    ST_DRAIN
  } bwg_state_t;

  function automatic logic [SEED_W-1:0] lcg_step(input logic [SEED_W-1:0] s);
    lcg_step = s * LCG_MUL + LCG_ADD;
  endfunction

endpackage

### src/bootstrap_weight_generator.sv
// Bootstrap resampling weight generator with a site-by-replicate weight memory.
`timescale 1ns / 1ps
// A generate request (operation 0) seeds the generator and clears the whole 65536-entry
// weight memory, one entry per cycle, writing weight 1 for replicate 0 at every site of
// the window as it goes; it then skips two draws and performs one draw per cycle for
// W x (R - 1) draws, W and R being the saturated window size and replicate count,
// through a read-increment-write pipeline on the single memory port pair.
// The generate time is set by the clear sweep and the one-draw-per-cycle memory update.
// A read request (operation 1) registers the memory word first in rdata_r and then in
// out_weight_r, which drives out_weight_value.
// Each request yields one result, shown for one cycle with out_valid; the receiver
// cannot stall it. Configuration registers may be written only while busy is low and
// no result is outstanding; cfg_ready is always high.
module bootstrap_weight_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [bwg_pkg::SITE_W-1:0]    in_site_index,
  input  logic [bwg_pkg::REP_W-1:0]     in_replicate_index,
  output logic                          out_valid,
  output logic [bwg_pkg::WEIGHT_W-1:0]  out_weight_value,
  output logic                          out_generate_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bwg_pkg::SEED_W-1:0]    cfg_data
);
  import bwg_pkg::*;

  // configuration
  logic [WIN_W-1:0]  win_size_r;
  logic [RCNT_W-1:0] replicate_count_r;
  logic [SEED_W-1:0] random_seed_r;

  // control
  bwg_state_t        state_r, state_nxt;
  logic [SEED_W-1:0] lcg_r, lcg_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [SITE_W-1:0] draw_r, draw_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic [SITE_W-1:0] wm1_r, wm1_nxt;
  logic [REP_W-1:0]  rm1_r, rm1_nxt;

  // pipeline
  logic              v1_r, v1_nxt;
  logic [REP_W-1:0]  rep1_r, rep1_nxt;
  logic              v2_r;
  logic [REP_W-1:0]  rep2_r;
  logic [PROD_W-1:0] p2_r;
  logic              v3_r;
  logic [ADDR_W-1:0] addr3_r;
  logic              wl_v_r;
  logic [ADDR_W-1:0] wl_addr_r;
  logic [WEIGHT_W-1:0] wl_data_r;

  // output
  logic                out_valid_r, out_valid_nxt;
  logic [WEIGHT_W-1:0] out_weight_r, out_weight_nxt;
  logic                out_done_r, out_done_nxt;

  // memory
  logic [WEIGHT_W-1:0] weight_store [2**ADDR_W];
  logic [WEIGHT_W-1:0] rdata_r;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [WEIGHT_W-1:0] mem_wd;
  logic [ADDR_W-1:0]   mem_ra;

  // derived
  logic [WIN_W-1:0]    w_sat;
  logic [RCNT_W-1:0]   r_sat;
  logic [SEED_W-1:0]   seed_eff;
  logic [SITE_W-1:0]   q0;
  logic [DRAW_W:0]     rem;
  logic [SITE_W:0]     q;
  logic [SITE_W-1:0]   s2;
  logic [ADDR_W-1:0]   addr2;
  logic [WEIGHT_W-1:0] base3;
  logic [WEIGHT_W-1:0] inc3;
  logic                clr_one;

  assign cfg_ready         = 1'b1;
  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_weight_value  = out_weight_r;
  assign out_generate_done = out_done_r;

  always_comb begin
    w_sat = win_size_r;
    if (win_size_r < MIN_WINDOW) w_sat = MIN_WINDOW;
    else if (win_size_r > WIN_W'(MAX_SITES)) w_sat = WIN_W'(MAX_SITES);
    r_sat = replicate_count_r;
    if (replicate_count_r == '0) r_sat = RCNT_W'(1);
    else if (replicate_count_r > RCNT_W'(MAX_REPLICATES)) r_sat = RCNT_W'(MAX_REPLICATES);
    seed_eff = (random_seed_r == '0) ? SEED_SUBST : random_seed_r;
  end

  // site = floor(p / 32767): p >> 15 underestimates by at most one
  always_comb begin
    q0   = p2_r[PROD_W-1:DRAW_W];
    rem  = {1'b0, p2_r[DRAW_W-1:0]} + (DRAW_W+1)'(q0);
    q    = (rem >= DRAW_MAX) ? ({1'b0, q0} + (SITE_W+1)'(1)) : {1'b0, q0};
    s2   = (q > {1'b0, wm1_r}) ? wm1_r : q[SITE_W-1:0];
    addr2 = {s2, rep2_r};
  end

  // forward the write of the previous cycle, which the read in flight missed
  always_comb begin
    base3 = (wl_v_r && (wl_addr_r == addr3_r)) ? wl_data_r : rdata_r;
    inc3  = base3 + WEIGHT_W'(1);
  end

  assign clr_one = (clr_r[REP_W-1:0] == '0) && (clr_r[ADDR_W-1:REP_W] <= wm1_r);

  always_comb begin
    mem_ra = (state_r == ST_IDLE) ? {in_site_index, in_replicate_index} : addr2;
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = clr_one ? WEIGHT_W'(1) : '0;
    if (v3_r) begin
      mem_we = 1'b1;
      mem_wa = addr3_r;
      mem_wd = inc3;
    end else if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    lcg_nxt        = lcg_r;
    clr_nxt        = clr_r;
    draw_nxt       = draw_r;
    rep_nxt        = rep_r;
    wm1_nxt        = wm1_r;
    rm1_nxt        = rm1_r;
    v1_nxt         = 1'b0;
    rep1_nxt       = rep1_r;
    out_valid_nxt  = 1'b0;
    out_weight_nxt = out_weight_r;
    out_done_nxt   = out_done_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_GENERATE) begin
            lcg_nxt   = seed_eff;
            clr_nxt   = '0;
            wm1_nxt   = SITE_W'(w_sat - WIN_W'(1));
            rm1_nxt   = REP_W'(r_sat - RCNT_W'(1));
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt  = 1'b1;
        out_weight_nxt = rdata_r;
        out_done_nxt   = 1'b0;
        state_nxt      = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == '1) state_nxt = ST_SKIP1;
      end
      ST_SKIP1: begin
        lcg_nxt   = lcg_step(lcg_r);
        state_nxt = ST_SKIP2;
      end
      ST_SKIP2: begin
        lcg_nxt  = lcg_step(lcg_r);
        draw_nxt = '0;
        rep_nxt  = REP_W'(1);
        if (rm1_r == '0) begin
          rep_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        lcg_nxt  = lcg_step(lcg_r);
        v1_nxt   = 1'b1;
        rep1_nxt = rep_r;
        if (rep_r == rm1_r) begin
          rep_nxt = REP_W'(1);
          if (draw_r == wm1_r) begin
            draw_nxt  = '0;
            rep_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            draw_nxt = draw_r + SITE_W'(1);
          end
        end else begin
          rep_nxt = rep_r + REP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          out_valid_nxt  = 1'b1;
          out_weight_nxt = '0;
          out_done_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r        <= WIN_RESET;
      replicate_count_r <= RCNT_RESET;
      random_seed_r     <= SEED_RESET;
      lcg_r             <= '0;
      clr_r             <= '0;
      draw_r            <= '0;
      rep_r             <= '0;
      wm1_r             <= '0;
      rm1_r             <= '0;
      v1_r              <= 1'b0;
      v2_r              <= 1'b0;
      v3_r              <= 1'b0;
      wl_v_r            <= 1'b0;
      out_valid_r       <= 1'b0;
      out_done_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_SITES:    win_size_r        <= cfg_data[WIN_W-1:0];
          CFG_REPLICATE_COUNT: replicate_count_r <= cfg_data[RCNT_W-1:0];
          CFG_RANDOM_SEED:     random_seed_r     <= cfg_data;
          default: ;
        endcase
      end
      lcg_r       <= lcg_nxt;
      clr_r       <= clr_nxt;
      draw_r      <= draw_nxt;
      rep_r       <= rep_nxt;
      wm1_r       <= wm1_nxt;
      rm1_r       <= rm1_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      wl_v_r      <= v3_r;
      out_valid_r <= out_valid_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rep1_r       <= rep1_nxt;
    rep2_r       <= rep1_r;
    p2_r         <= PROD_W'(lcg_r[DRAW_W+15:16]) * PROD_W'(wm1_r);
    addr3_r      <= addr2;
    wl_addr_r    <= addr3_r;
    wl_data_r    <= inc3;
    out_weight_r <= out_weight_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) weight_store[mem_wa] <= mem_wd;
    rdata_r <= weight_store[mem_ra];
  end

endmodule
